>>> rtl/vcmt_pkg.sv
// ----------------------------------------------------------------------------
// vcmt_pkg: shared types and constants of the versioned commit map table
// Item and result layouts, commit record layout, compare unit request and
// the sizing constants of the object table and commit rings.
// ----------------------------------------------------------------------------
package vcmt_pkg;

  // Table sizing
  localparam int NUM_OBJECTS = 16;
  localparam int RING_DEPTH  = 4;

  localparam int OBJ_W     = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
  localparam int SLOT_W    = $clog2(RING_DEPTH);
  localparam int REC_COUNT = NUM_OBJECTS * RING_DEPTH;
  localparam int REC_AW    = (REC_COUNT > 1) ? $clog2(REC_COUNT) : 1;

  // Operation codes carried in the kind field
  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_COMMIT = 2'd1,
    KIND_CHECK  = 2'd2,
    KIND_FIND   = 2'd3
  } kind_t;

  // Check result codes
  localparam logic [1:0] ST_ABORTED   = 2'd0;
  localparam logic [1:0] ST_COMMITTED = 2'd1;
  localparam logic [1:0] ST_PENDING   = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  object_index;
    logic [31:0] task_id;
    logic [7:0]  node_addr;
    logic [31:0] data_address;
    logic [31:0] valid_start;
    logic [31:0] valid_stop;
    logic [31:0] query_point;
  } req_t;

  typedef struct packed {
    logic [31:0] ret_address;
    logic [31:0] cur_start;
    logic [31:0] cur_stop;
    logic [1:0]  commit_status;
    logic [31:0] found_start;
  } rsp_t;

  // One commit record of an object's ring
  typedef struct packed {
    logic        sel;
    logic [31:0] start;
    logic [31:0] stop;
    logic [31:0] task_id;
    logic [7:0]  node;
  } rec_t;

  // Compare unit operations
  typedef enum logic [1:0] {
    CMP_GT,
    CMP_EQ,
    CMP_RANGE
  } cmp_op_t;

  typedef struct packed {
    cmp_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [7:0]  node_a;
    logic [7:0]  node_b;
  } cmp_req_t;

endpackage

>>> rtl/versioned_commit_map_table.sv
// ----------------------------------------------------------------------------
// versioned_commit_map_table: per-object commit record table
// Keeps a ring of commit records and two data address buffers per object and
// serves read, commit, check and find-start operations.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid, req_stall, req) carries one operation; it
//   transfers at a clock edge with req_valid high and req_stall low. Every
//   request gives exactly one response on (rsp_valid, rsp_stall, rsp), which
//   transfers when rsp_valid is high and rsp_stall low.
//   A small sequencer walks the records of the addressed object through one
//   record store read port and one shared compare unit; each record read
//   passes a look state and an evaluate state. Read and commit read the head
//   record; check reads the record after head and, unless aborted, walks the
//   ring from slot zero; find-start walks the ring from slot zero and may end
//   in a wrap test; an object out of range goes straight to the response.
//   One request is in work at a time; req_stall is high while it is.
//   A finished response waits in an output register, so the next request is
//   taken while the receiver stalls; a further result holds in the sequencer
//   until that register is free.
//   Reset clears all records, heads and address buffers at once; the block
//   takes a request in the first cycle after reset.
// ----------------------------------------------------------------------------
module versioned_commit_map_table (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  vcmt_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output vcmt_pkg::rsp_t   rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_EVAL,
    S_WRAP,
    S_DONE
  } state_t;

  localparam logic [vcmt_pkg::SLOT_W-1:0] LAST_SLOT =
    vcmt_pkg::SLOT_W'(vcmt_pkg::RING_DEPTH - 1);

  state_t                           state;
  vcmt_pkg::req_t                   item;
  logic [vcmt_pkg::OBJ_W-1:0]       obj;
  logic [vcmt_pkg::SLOT_W-1:0]      slot;
  logic                             age_phase;
  logic [31:0]                      prev_start;
  logic [31:0]                      first_start;
  vcmt_pkg::rsp_t                   res;

  logic [vcmt_pkg::SLOT_W-1:0]      head  [vcmt_pkg::NUM_OBJECTS];
  logic [31:0]                      abuf  [vcmt_pkg::NUM_OBJECTS];
  logic [31:0]                      bbuf  [vcmt_pkg::NUM_OBJECTS];

  logic                             accept;
  logic                             out_free;
  logic                             rsp_load;
  logic [vcmt_pkg::OBJ_W-1:0]       req_obj;
  logic                             req_obj_ok;
  logic [vcmt_pkg::SLOT_W-1:0]      req_head;
  logic [vcmt_pkg::SLOT_W-1:0]      slot_after;

  logic                             mem_wr_en;
  logic [vcmt_pkg::REC_AW-1:0]      mem_wr_addr;
  vcmt_pkg::rec_t                   mem_wr_rec;
  logic                             mem_rd_en;
  logic [vcmt_pkg::REC_AW-1:0]      mem_rd_addr;
  vcmt_pkg::rec_t                   rec;

  vcmt_pkg::cmp_req_t               cmp_req;
  logic                             cmp_hit;

  function automatic logic [vcmt_pkg::SLOT_W-1:0] next_slot(
    input logic [vcmt_pkg::SLOT_W-1:0] s
  );
    return (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [vcmt_pkg::REC_AW-1:0] rec_addr(
    input logic [vcmt_pkg::OBJ_W-1:0]  o,
    input logic [vcmt_pkg::SLOT_W-1:0] s
  );
    return vcmt_pkg::REC_AW'(o) * vcmt_pkg::REC_AW'(vcmt_pkg::RING_DEPTH)
         + vcmt_pkg::REC_AW'(s);
  endfunction

  // Handshake
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign rsp_load  = (state == S_DONE) && out_free;

  // Decode the incoming object
  assign req_obj    = vcmt_pkg::OBJ_W'(req.object_index);
  assign req_obj_ok = ({28'd0, req.object_index} < 32'(vcmt_pkg::NUM_OBJECTS));
  assign req_head   = head[req_obj];
  assign slot_after = next_slot(slot);

  // Record store ports
  assign mem_rd_en   = (state == S_LOOK);
  assign mem_rd_addr = rec_addr(obj, slot);

  assign mem_wr_en   = (state == S_EVAL) &&
                       (vcmt_pkg::kind_t'(item.kind) == vcmt_pkg::KIND_COMMIT);
  assign mem_wr_addr = rec_addr(obj, slot_after);
  assign mem_wr_rec  = '{sel:     !rec.sel,
                         start:   item.valid_start,
                         stop:    item.valid_stop,
                         task_id: item.task_id,
                         node:    item.node_addr};

  vcmt_rec_mem u_rec_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_rec  (mem_wr_rec),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_rec  (rec)
  );

  // Build the compare for this step
  always_comb begin
    cmp_req        = '0;
    cmp_req.op     = vcmt_pkg::CMP_RANGE;
    cmp_req.node_a = rec.node;
    cmp_req.node_b = item.node_addr;
    if (state == S_WRAP) begin
      cmp_req.a = prev_start;
      cmp_req.b = item.query_point;
      cmp_req.c = first_start;
    end else if (vcmt_pkg::kind_t'(item.kind) == vcmt_pkg::KIND_CHECK) begin
      cmp_req.op = age_phase ? vcmt_pkg::CMP_GT : vcmt_pkg::CMP_EQ;
      cmp_req.a  = rec.task_id;
      cmp_req.b  = item.task_id;
    end else begin
      cmp_req.a = prev_start;
      cmp_req.b = item.query_point;
      cmp_req.c = rec.start;
    end
  end

  vcmt_cmp_unit u_cmp (
    .req (cmp_req),
    .hit (cmp_hit)
  );

  // Sequencer, object stores and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      for (int i = 0; i < vcmt_pkg::NUM_OBJECTS; i++) begin
        head[i] <= '0;
        abuf[i] <= '0;
        bbuf[i] <= '0;
      end
    end else begin
      // raise on a new response, hold while stalled, drop once it transfers
      rsp_valid <= rsp_load || (rsp_valid && rsp_stall);

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            item      <= req;
            obj       <= req_obj;
            res       <= '0;
            age_phase <= 1'b1;
            if (!req_obj_ok) begin
              state <= S_DONE;
            end else begin
              state <= S_LOOK;
              unique case (vcmt_pkg::kind_t'(req.kind))
                vcmt_pkg::KIND_READ:   slot <= req_head;
                vcmt_pkg::KIND_COMMIT: slot <= req_head;
                vcmt_pkg::KIND_CHECK:  slot <= next_slot(req_head);
                vcmt_pkg::KIND_FIND:   slot <= '0;
                default:               slot <= '0;
              endcase
            end
          end
        end

        S_LOOK: begin
          state <= S_EVAL;
        end

        S_EVAL: begin
          unique case (vcmt_pkg::kind_t'(item.kind))
            vcmt_pkg::KIND_READ: begin
              res.ret_address <= rec.sel ? bbuf[obj] : abuf[obj];
              res.cur_start   <= rec.start;
              res.cur_stop    <= rec.stop;
              state           <= S_DONE;
            end

            vcmt_pkg::KIND_COMMIT: begin
              // fill the buffer the head record does not use, advance head
              if (rec.sel) begin
                abuf[obj] <= item.data_address;
              end else begin
                bbuf[obj] <= item.data_address;
              end
              head[obj] <= slot_after;
              state     <= S_DONE;
            end

            vcmt_pkg::KIND_CHECK: begin
              if (age_phase) begin
                if (cmp_hit) begin
                  res.commit_status <= vcmt_pkg::ST_ABORTED;
                  state             <= S_DONE;
                end else begin
                  age_phase <= 1'b0;
                  slot      <= '0;
                  state     <= S_LOOK;
                end
              end else if (cmp_hit) begin
                res.commit_status <= vcmt_pkg::ST_COMMITTED;
                state             <= S_DONE;
              end else if (slot == LAST_SLOT) begin
                res.commit_status <= vcmt_pkg::ST_PENDING;
                state             <= S_DONE;
              end else begin
                slot  <= slot_after;
                state <= S_LOOK;
              end
            end

            vcmt_pkg::KIND_FIND: begin
              prev_start <= rec.start;
              if (slot == '0) begin
                first_start <= rec.start;
                slot        <= slot_after;
                state       <= S_LOOK;
              end else if (cmp_hit) begin
                res.found_start <= rec.start;
                state           <= S_DONE;
              end else if (slot == LAST_SLOT) begin
                state <= S_WRAP;
              end else begin
                slot  <= slot_after;
                state <= S_LOOK;
              end
            end

            default: begin
              state <= S_DONE;
            end
          endcase
        end

        S_WRAP: begin
          // last record against the first one
          if (cmp_hit) begin
            res.found_start <= first_start;
          end
          state <= S_DONE;
        end

        S_DONE: begin
          if (out_free) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/vcmt_rec_mem.sv
// ----------------------------------------------------------------------------
// vcmt_rec_mem: commit record store
// One write and one registered read port over all records of all objects.
// A valid bit per record makes never-written records read as zero.
// ----------------------------------------------------------------------------
module vcmt_rec_mem (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [vcmt_pkg::REC_AW-1:0] wr_addr,
  input  vcmt_pkg::rec_t             wr_rec,
  input  logic                       rd_en,
  input  logic [vcmt_pkg::REC_AW-1:0] rd_addr,
  output vcmt_pkg::rec_t             rd_rec
);

  vcmt_pkg::rec_t                     mem [vcmt_pkg::REC_COUNT];
  logic [vcmt_pkg::REC_COUNT-1:0]     vld;
  vcmt_pkg::rec_t                     rd_raw;
  logic                               rd_vld;

  // Record array: write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // Valid bits: clear on reset, set on write
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  // Mask records never written
  assign rd_rec = rd_vld ? rd_raw : '0;

endmodule

>>> rtl/vcmt_cmp_unit.sv
// ----------------------------------------------------------------------------
// vcmt_cmp_unit: shared compare unit
// Serves the age test, the task match and the interval test of the
// sequencer, one compare per cycle.
// ----------------------------------------------------------------------------
module vcmt_cmp_unit (
  input  vcmt_pkg::cmp_req_t req,
  output logic               hit
);

  // Select the compare for the requested operation
  always_comb begin
    unique case (req.op)
      vcmt_pkg::CMP_GT:    hit = (req.a > req.b);
      vcmt_pkg::CMP_EQ:    hit = (req.a == req.b) && (req.node_a == req.node_b);
      vcmt_pkg::CMP_RANGE: hit = (req.a <= req.b) && (req.b < req.c);
      default:             hit = 1'b0;
    endcase
  end

endmodule

>>> tb/versioned_commit_map_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// versioned_commit_map_table_test: self-checking bench for the commit table
// Drives a short directed table (reset state, all-ones and all-zero fields,
// ring wrap, aborted/committed/pending, the wrap case of find-start), then
// random operations built mostly as ordered commit histories per object.
// Each response is compared field by field with a typed expectation or an
// in-bench model, under three idling phases on both channels.
// ----------------------------------------------------------------------------
module versioned_commit_map_table_test;

  localparam logic [31:0] JUNK = 32'h5A5A_A5A5;
  localparam logic [31:0] ONES = 32'hFFFF_FFFF;
  localparam int RANDOM_PER_PHASE = 150;
  localparam int SETTLE_CYCLES = 16;

  typedef struct {
    vcmt_pkg::req_t op;
    bit             typed;
    vcmt_pkg::rsp_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  vcmt_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  vcmt_pkg::rsp_t rsp;

  // Model of the table state
  int             tbl_head  [vcmt_pkg::NUM_OBJECTS] = '{default: 0};
  logic [31:0]    tbl_buf_a [vcmt_pkg::NUM_OBJECTS] = '{default: '0};
  logic [31:0]    tbl_buf_b [vcmt_pkg::NUM_OBJECTS] = '{default: '0};
  vcmt_pkg::rec_t tbl_rec   [vcmt_pkg::NUM_OBJECTS][vcmt_pkg::RING_DEPTH] =
    '{default: '0};

  // Running task ids and starts for ordered commit histories
  logic [31:0] task_hi  [vcmt_pkg::NUM_OBJECTS] = '{default: '0};
  logic [31:0] start_hi [vcmt_pkg::NUM_OBJECTS] = '{default: '0};

  vcmt_pkg::rsp_t rsp_due_q [$];
  row_t dir_rows [$];
  int   fail_count = 0;
  int   send_idle_pct = 33;
  int   recv_idle_pct = 62;
  int   kind_seen [4] = '{default: 0};
  int   status_seen [3] = '{default: 0};
  int   find_hits = 0;

  versioned_commit_map_table i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // End the run if it hangs
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int ring_next(int h);
    return (h == vcmt_pkg::RING_DEPTH - 1) ? 0 : h + 1;
  endfunction

  // Apply one operation to the table model and return its response
  function automatic vcmt_pkg::rsp_t perform_table_op(vcmt_pkg::req_t r);
    vcmt_pkg::rsp_t res;
    int obj;
    int h;
    int nx;
    logic [1:0] st;
    res = '0;
    obj = int'(r.object_index);
    if (obj >= vcmt_pkg::NUM_OBJECTS) return res;
    h = tbl_head[obj];
    nx = ring_next(h);
    case (r.kind)
      vcmt_pkg::KIND_READ: begin
        res.ret_address = tbl_rec[obj][h].sel ? tbl_buf_b[obj] : tbl_buf_a[obj];
        res.cur_start = tbl_rec[obj][h].start;
        res.cur_stop = tbl_rec[obj][h].stop;
      end
      vcmt_pkg::KIND_COMMIT: begin
        // write into the buffer that the head record does not select
        if (tbl_rec[obj][h].sel) begin
          tbl_buf_a[obj] = r.data_address;
          tbl_rec[obj][nx].sel = 1'b0;
        end else begin
          tbl_buf_b[obj] = r.data_address;
          tbl_rec[obj][nx].sel = 1'b1;
        end
        tbl_rec[obj][nx].start = r.valid_start;
        tbl_rec[obj][nx].stop = r.valid_stop;
        tbl_rec[obj][nx].task_id = r.task_id;
        tbl_rec[obj][nx].node = r.node_addr;
        tbl_head[obj] = nx;
      end
      vcmt_pkg::KIND_CHECK: begin
        st = vcmt_pkg::ST_PENDING;
        if (tbl_rec[obj][nx].task_id > r.task_id) begin
          st = vcmt_pkg::ST_ABORTED;
        end else begin
          for (int i = 0; i < vcmt_pkg::RING_DEPTH; i++) begin
            if (tbl_rec[obj][i].node == r.node_addr &&
                tbl_rec[obj][i].task_id == r.task_id)
              st = vcmt_pkg::ST_COMMITTED;
          end
        end
        res.commit_status = st;
      end
      default: begin
        // first bracketing pair wins; the last-to-first pair only as fallback
        for (int i = 0; i < vcmt_pkg::RING_DEPTH - 1; i++) begin
          if (res.found_start == 0 && tbl_rec[obj][i].start <= r.query_point &&
              r.query_point < tbl_rec[obj][i + 1].start) begin
            res.found_start = tbl_rec[obj][i + 1].start;
            break;
          end
        end
        if (res.found_start == 0 &&
            tbl_rec[obj][vcmt_pkg::RING_DEPTH - 1].start <= r.query_point &&
            r.query_point < tbl_rec[obj][0].start)
          res.found_start = tbl_rec[obj][0].start;
      end
    endcase
    return res;
  endfunction

  function automatic vcmt_pkg::req_t op_item(vcmt_pkg::kind_t k, logic [3:0] obj,
                                             logic [31:0] tid, logic [7:0] node,
                                             logic [31:0] addr, logic [31:0] vstart,
                                             logic [31:0] vstop, logic [31:0] qpoint);
    vcmt_pkg::req_t r;
    r.kind = k;
    r.object_index = obj;
    r.task_id = tid;
    r.node_addr = node;
    r.data_address = addr;
    r.valid_start = vstart;
    r.valid_stop = vstop;
    r.query_point = qpoint;
    return r;
  endfunction

  function automatic void add_row(vcmt_pkg::req_t op, bit typed, vcmt_pkg::rsp_t want);
    row_t rw;
    rw.op = op;
    rw.typed = typed;
    rw.want = want;
    dir_rows.push_back(rw);
  endfunction

  // Random operation: mostly ordered commits and queries aimed at stored records
  function automatic vcmt_pkg::req_t random_op();
    vcmt_pkg::req_t r;
    int obj;
    int pick;
    int slot;
    obj = ($urandom_range(1) == 0) ? int'($urandom_range(3)) : int'($urandom_range(15));
    slot = int'($urandom_range(vcmt_pkg::RING_DEPTH - 1));
    pick = int'($urandom_range(99));
    r.object_index = 4'(obj);
    r.task_id = $urandom();
    r.node_addr = 8'($urandom_range(255));
    r.data_address = $urandom();
    r.valid_start = $urandom();
    r.valid_stop = $urandom();
    r.query_point = $urandom();
    if (pick < 35) begin
      r.kind = vcmt_pkg::KIND_COMMIT;
      if ($urandom_range(5) != 0) begin
        task_hi[obj] += $urandom_range(1, 8);
        start_hi[obj] += $urandom_range(1, 400);
        r.task_id = task_hi[obj];
        r.valid_start = start_hi[obj];
        r.valid_stop = start_hi[obj] + $urandom_range(400);
      end
    end else if (pick < 55) begin
      r.kind = vcmt_pkg::KIND_READ;
    end else if (pick < 80) begin
      r.kind = vcmt_pkg::KIND_CHECK;
      pick = int'($urandom_range(9));
      if (pick < 6) begin
        r.task_id = tbl_rec[obj][slot].task_id;
        if (pick < 4) r.node_addr = tbl_rec[obj][slot].node;
      end else if (pick < 8) begin
        r.task_id = tbl_rec[obj][ring_next(tbl_head[obj])].task_id - 32'd1;
      end
    end else begin
      r.kind = vcmt_pkg::KIND_FIND;
      pick = int'($urandom_range(9));
      if (pick < 6) r.query_point = tbl_rec[obj][slot].start + $urandom_range(300);
      else if (pick < 8) r.query_point = tbl_rec[obj][slot].start - 32'd1;
    end
    return r;
  endfunction

  // Offer one request, hold it until it transfers, then file its response
  task automatic transfer_req(vcmt_pkg::req_t op, vcmt_pkg::rsp_t want);
    req <= op;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    rsp_due_q.push_back(want);
    kind_seen[op.kind]++;
    if (op.kind == vcmt_pkg::KIND_CHECK && want.commit_status <= vcmt_pkg::ST_PENDING)
      status_seen[want.commit_status]++;
    if (op.kind == vcmt_pkg::KIND_FIND && want.found_start != 0) find_hits++;
  endtask

  // Drop valid for a random number of cycles at the current idling ratio
  task automatic sender_pause();
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Hold off until every filed response has come back
  task automatic drain_responses();
    req_valid <= 1'b0;
    do @(posedge clk); while (rsp_due_q.size() != 0);
  endtask

  function automatic void check_field(string label, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      fail_count++;
    end
  endfunction

  // Response side: stall at random and compare each transfer
  always @(posedge clk) begin
    vcmt_pkg::rsp_t want;
    rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    if (!rst && rsp_valid && !rsp_stall) begin
      if (rsp_due_q.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual %h", $time, rsp);
        fail_count++;
      end else begin
        want = rsp_due_q.pop_front();
        check_field("ret_address", want.ret_address, rsp.ret_address);
        check_field("cur_start", want.cur_start, rsp.cur_start);
        check_field("cur_stop", want.cur_stop, rsp.cur_stop);
        check_field("commit_status", {30'd0, want.commit_status}, {30'd0, rsp.commit_status});
        check_field("found_start", want.found_start, rsp.found_start);
      end
    end
  end

  initial begin
    vcmt_pkg::rsp_t want;
    vcmt_pkg::req_t op;

    // reset state, then all-ones commit on the top object
    add_row(op_item(vcmt_pkg::KIND_READ, 4'd0, JUNK, 8'hA5, JUNK, JUNK, JUNK, JUNK),
            1'b1, '0);
    add_row(op_item(vcmt_pkg::KIND_CHECK, 4'd0, 32'd0, 8'd0, JUNK, JUNK, JUNK, JUNK),
            1'b1, {96'd0, vcmt_pkg::ST_COMMITTED, 32'd0});
    add_row(op_item(vcmt_pkg::KIND_FIND, 4'd0, JUNK, 8'h5A, JUNK, JUNK, JUNK, 32'd0),
            1'b1, '0);
    add_row(op_item(vcmt_pkg::KIND_FIND, 4'd0, JUNK, 8'h5A, JUNK, JUNK, JUNK, ONES),
            1'b1, '0);
    add_row(op_item(vcmt_pkg::KIND_COMMIT, 4'd15, ONES, 8'hFF, ONES, ONES, ONES, ONES),
            1'b1, '0);
    add_row(op_item(vcmt_pkg::KIND_READ, 4'd15, 32'd0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0),
            1'b1, {ONES, ONES, ONES, vcmt_pkg::ST_ABORTED, 32'd0});
    add_row(op_item(vcmt_pkg::KIND_CHECK, 4'd15, ONES, 8'hFF, 32'd0, 32'd0, 32'd0, 32'd0),
            1'b1, {96'd0, vcmt_pkg::ST_COMMITTED, 32'd0});
    add_row(op_item(vcmt_pkg::KIND_CHECK, 4'd15, 32'hFFFF_FFFE, 8'h01, ONES, ONES, ONES,
                    ONES), 1'b1, {96'd0, vcmt_pkg::ST_PENDING, 32'd0});
    add_row(op_item(vcmt_pkg::KIND_FIND, 4'd15, ONES, 8'hFF, ONES, ONES, ONES,
                    32'hFFFF_FFFE), 1'b0, '0);
    add_row(op_item(vcmt_pkg::KIND_FIND, 4'd15, ONES, 8'hFF, ONES, ONES, ONES, ONES),
            1'b0, '0);
    // fill one ring completely so the head wraps
    add_row(op_item(vcmt_pkg::KIND_COMMIT, 4'd1, 32'd10, 8'd3, 32'h1000, 32'd100, 32'd150,
                    JUNK), 1'b1, '0);
    add_row(op_item(vcmt_pkg::KIND_COMMIT, 4'd1, 32'd20, 8'd3, 32'h2000, 32'd200, 32'd250,
                    JUNK), 1'b1, '0);
    add_row(op_item(vcmt_pkg::KIND_COMMIT, 4'd1, 32'd30, 8'd3, 32'h3000, 32'd300, 32'd350,
                    JUNK), 1'b1, '0);
    add_row(op_item(vcmt_pkg::KIND_COMMIT, 4'd1, 32'd40, 8'd3, 32'h4000, 32'd400, 32'd450,
                    JUNK), 1'b1, '0);
    add_row(op_item(vcmt_pkg::KIND_READ, 4'd1, JUNK, 8'h33, JUNK, JUNK, JUNK, JUNK),
            1'b0, '0);
    // older than the oldest record: aborted
    add_row(op_item(vcmt_pkg::KIND_CHECK, 4'd1, 32'd5, 8'd3, JUNK, JUNK, JUNK, JUNK),
            1'b1, '0);
    add_row(op_item(vcmt_pkg::KIND_CHECK, 4'd1, 32'd30, 8'd3, JUNK, JUNK, JUNK, JUNK),
            1'b0, '0);
    add_row(op_item(vcmt_pkg::KIND_CHECK, 4'd1, 32'd30, 8'd4, JUNK, JUNK, JUNK, JUNK),
            1'b0, '0);
    add_row(op_item(vcmt_pkg::KIND_FIND, 4'd1, JUNK, 8'h00, JUNK, JUNK, JUNK, 32'd150),
            1'b0, '0);
    // query between the last and the first record: the wrap case
    add_row(op_item(vcmt_pkg::KIND_FIND, 4'd1, JUNK, 8'h00, JUNK, JUNK, JUNK, 32'd350),
            1'b0, '0);
    add_row(op_item(vcmt_pkg::KIND_FIND, 4'd1, JUNK, 8'h00, JUNK, JUNK, JUNK, 32'd500),
            1'b0, '0);
    add_row(op_item(vcmt_pkg::KIND_COMMIT, 4'd1, 32'd50, 8'd0, 32'd0, 32'd0, 32'd0, ONES),
            1'b1, '0);
    add_row(op_item(vcmt_pkg::KIND_READ, 4'd1, ONES, 8'hFF, ONES, ONES, ONES, ONES),
            1'b0, '0);
    add_row(op_item(vcmt_pkg::KIND_COMMIT, 4'd15, 32'd0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0),
            1'b1, '0);
    add_row(op_item(vcmt_pkg::KIND_READ, 4'd15, ONES, 8'hFF, ONES, ONES, ONES, ONES),
            1'b0, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table, typed expectations where given
    foreach (dir_rows[i]) begin
      want = perform_table_op(dir_rows[i].op);
      if (dir_rows[i].typed) want = dir_rows[i].want;
      transfer_req(dir_rows[i].op, want);
      sender_pause();
    end
    drain_responses();

    // random phases: sender light / receiver heavy, swapped, then no idling
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 62 : 0;
      recv_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 33 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        op = random_op();
        transfer_req(op, perform_table_op(op));
        sender_pause();
      end
      drain_responses();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (rsp_due_q.size() != 0) begin
      $display("%0t: %0d responses missing", $time, rsp_due_q.size());
      fail_count++;
    end
    $display("covered %0d reads, %0d commits, %0d checks, %0d find-starts in three idling phases",
             kind_seen[vcmt_pkg::KIND_READ], kind_seen[vcmt_pkg::KIND_COMMIT],
             kind_seen[vcmt_pkg::KIND_CHECK], kind_seen[vcmt_pkg::KIND_FIND]);
    $display("checks: %0d aborted, %0d committed, %0d pending; %0d find-starts hit a record",
             status_seen[vcmt_pkg::ST_ABORTED], status_seen[vcmt_pkg::ST_COMMITTED],
             status_seen[vcmt_pkg::ST_PENDING], find_hits);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/vcmt_pkg.sv
rtl/vcmt_rec_mem.sv
rtl/vcmt_cmp_unit.sv
rtl/versioned_commit_map_table.sv
tb/versioned_commit_map_table_test.sv
